// ===== sv/gbop_pkg.sv =====
// gbop_pkg: types and constants for the offset planner
// used by gbop_cell, gbop_scan and greedy_breadth_offset_planner_core
package gbop_pkg;
	localparam int unsigned TableDepthDefault = 256;
	localparam logic [30:0] IntMax = 31'h7FFF_FFFF;

	localparam logic [1:0] StatusNew = 2'd0;
	localparam logic [1:0] StatusFound = 2'd1;
	localparam logic [1:0] StatusFull = 2'd2;

	typedef struct packed {
		logic [9:0] id;
		logic [15:0] first;
		logic [15:0] last;
		logic [30:0] offset;
		logic [30:0] size;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_INSERT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic shift;  // rotate the ring by one
		logic load;   // write the new entry at cell zero
		logic clear;  // drop all valid bits
	} ctl_t;
endpackage

// ===== sv/gbop_cell.sv =====
// gbop_cell: one slot of the placed-tensor ring
// depends on gbop_pkg
module gbop_cell (
	input logic clk,
	input logic arst_n,
	input gbop_pkg::ctl_t ctl,
	input gbop_pkg::entry_t prev_entry,
	input logic prev_valid,
	input gbop_pkg::entry_t load_entry,
	output gbop_pkg::entry_t entry,
	output logic valid
);
	gbop_pkg::entry_t entry_q;
	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (ctl.shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= load_entry;
		end else if (ctl.shift) begin
			entry_q <= prev_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;
endmodule

// ===== sv/gbop_scan.sv =====
// gbop_scan: per-entry id match and gap search step on the ring head
// depends on gbop_pkg
module gbop_scan (
	input logic clk,
	input logic start_scan,
	input logic step,
	input gbop_pkg::entry_t head,
	input logic [9:0] id,
	input logic [15:0] first,
	input logic [15:0] last,
	input logic [30:0] size,
	output logic hit,
	output logic [30:0] hit_offset,
	output logic [31:0] best
);
	logic [31:0] prev_q, best_q, small_q;
	logic found_q, hit_q;
	logic [30:0] hit_off_q;
	logic [15:0] lo, hi;
	logic [31:0] xo, xe, gap;
	logic fits;

	always_comb begin
		lo = (first > head.first) ? first : head.first;
		hi = (last < head.last) ? last : head.last;
		xo = {1'b0, head.offset};
		xe = {1'b0, head.offset} + {1'b0, head.size};
		gap = xo - prev_q;
		fits = (lo <= hi) && (xo >= prev_q) && (gap >= {1'b0, size})
			&& (!found_q || gap < small_q);
	end

	always_ff @(posedge clk) begin
		if (start_scan) begin
			prev_q <= '0;
			best_q <= '0;
			small_q <= '0;
			found_q <= 1'b0;
			hit_q <= 1'b0;
		end else if (step) begin
			if (head.id == id && !hit_q) begin
				hit_q <= 1'b1;
				hit_off_q <= head.offset;
			end
			if (fits) begin
				small_q <= gap;
				best_q <= prev_q;
				found_q <= 1'b1;
			end
			if (lo <= hi && xe > prev_q) prev_q <= xe;
		end
	end

	assign hit = hit_q;
	assign hit_offset = hit_off_q;
	assign best = found_q ? best_q : prev_q;
endmodule

// ===== sv/greedy_breadth_offset_planner_core.sv =====
// greedy_breadth_offset_planner_core: top level of the tensor offset planner
// depends on gbop_pkg, gbop_cell, gbop_scan
//
// channel   direction  signals
// request   in         start, busy, new_plan, tensor_id, first_use, last_use, tensor_size
// result    out        done, offset, status, footprint
//
// the placed table is a ring of TABLE_DEPTH cells kept sorted by offset from the
// head; one full rotation of the ring scans every entry, the insert phase rotates
// it once more and slips the new entry in ahead of the first larger offset
// a request that inserts runs the scan rotation, the insert rotation and the done
// state before its result; one whose id is found or that finds the table full
// skips the insert rotation; busy drops as the result shows, so the next request
// can be accepted at the edge that takes the result
// reset clears the valid bits, the count and the peak; no clearing pass
// a result shows for one cycle on done and cannot be stalled
module greedy_breadth_offset_planner_core #(
	parameter int unsigned TABLE_DEPTH = gbop_pkg::TableDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic new_plan,
	input logic [9:0] tensor_id,
	input logic [15:0] first_use,
	input logic [15:0] last_use,
	input logic [30:0] tensor_size,
	output logic done,
	output logic [30:0] offset,
	output logic [1:0] status,
	output logic [30:0] footprint
);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	gbop_pkg::state_t state_q, state_d;
	gbop_pkg::entry_t req_q;
	gbop_pkg::entry_t cell_e [TABLE_DEPTH];
	logic cell_v [TABLE_DEPTH];
	gbop_pkg::ctl_t ctl [TABLE_DEPTH];
	logic [CW-1:0] count_q, step_q;
	logic [30:0] peak_q, off_q;
	logic [1:0] stat_q;
	logic done_q, inserted_q;
	logic hit;
	logic [30:0] hit_off;
	logic [31:0] best;
	logic [30:0] new_off;
	logic [31:0] end_sum;
	logic [30:0] end_sat;
	gbop_pkg::entry_t new_e;
	logic accept, scan_step, last_step, full;
	logic ring_shift, ring_load;

	assign accept = start && !busy;
	assign busy = (state_q != gbop_pkg::ST_IDLE);
	assign full = (count_q == CW'(TABLE_DEPTH));
	assign last_step = (step_q == CW'(TABLE_DEPTH - 1));
	assign scan_step = (state_q == gbop_pkg::ST_SCAN) && (step_q < count_q);

	// saturate the chosen offset and the end of the new tensor
	assign new_off = best[31] ? gbop_pkg::IntMax : best[30:0];
	assign end_sum = {1'b0, new_off} + {1'b0, req_q.size};
	assign end_sat = end_sum[31] ? gbop_pkg::IntMax : end_sum[30:0];
	always_comb begin
		new_e = req_q;
		new_e.offset = new_off;
	end

	// insert phase: rotate the ring once; the new entry enters the tail when the
	// head is the first valid entry with a larger offset, or the first free slot,
	// so the ring stays sorted
	logic head_after;
	assign head_after = !cell_v[TABLE_DEPTH-1]
		|| (cell_e[TABLE_DEPTH-1].offset > new_off);
	assign ring_load = (state_q == gbop_pkg::ST_INSERT) && !inserted_q && head_after;
	assign ring_shift = (state_q == gbop_pkg::ST_SCAN)
		|| ((state_q == gbop_pkg::ST_INSERT) && !ring_load);

	// once the new entry is in, the tail takes the head held back in carry_q;
	// the entry held at the end of the rotation is the last free slot
	gbop_pkg::entry_t carry_q;
	logic carry_v_q;
	gbop_pkg::entry_t tail_e;
	logic tail_v;
	assign tail_e = inserted_q ? carry_q : cell_e[TABLE_DEPTH-1];
	assign tail_v = inserted_q ? carry_v_q : cell_v[TABLE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_v_q <= 1'b0;
		end else begin
			carry_v_q <= cell_v[TABLE_DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		carry_q <= cell_e[TABLE_DEPTH-1];
	end

	gbop_scan u_scan (
		.clk(clk),
		.start_scan(accept),
		.step(scan_step),
		.head(cell_e[TABLE_DEPTH-1]),
		.id(req_q.id),
		.first(req_q.first),
		.last(req_q.last),
		.size(req_q.size),
		.hit(hit),
		.hit_offset(hit_off),
		.best(best)
	);

	// ring of cells; cell zero takes from the tail source or the new entry
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		always_comb begin
			ctl[g].clear = accept && new_plan;
			ctl[g].load = ring_load && (g == 0);
			ctl[g].shift = ring_shift || ring_load;
		end
		gbop_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl[g]),
			.prev_entry((g == 0) ? tail_e : cell_e[(g + TABLE_DEPTH - 1) % TABLE_DEPTH]),
			.prev_valid((g == 0) ? tail_v : cell_v[(g + TABLE_DEPTH - 1) % TABLE_DEPTH]),
			.load_entry(new_e),
			.entry(cell_e[g]),
			.valid(cell_v[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbop_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gbop_pkg::ST_IDLE: begin
				if (accept) state_d = gbop_pkg::ST_SCAN;
			end
			gbop_pkg::ST_SCAN: begin
				if (last_step) state_d = (hit || full) ? gbop_pkg::ST_DONE
					: gbop_pkg::ST_INSERT;
			end
			gbop_pkg::ST_INSERT: begin
				if (last_step) state_d = gbop_pkg::ST_DONE;
			end
			gbop_pkg::ST_DONE: state_d = gbop_pkg::ST_IDLE;
			default: state_d = gbop_pkg::ST_IDLE;
		endcase
	end

	// the scan result of the final step is registered in gbop_scan, so the
	// hit flag is checked once more in the done state (hit seen next cycle)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			peak_q <= '0;
			step_q <= '0;
			done_q <= 1'b0;
			inserted_q <= 1'b0;
		end else begin
			done_q <= (state_q == gbop_pkg::ST_DONE);
			if (accept) begin
				step_q <= '0;
				inserted_q <= 1'b0;
				if (new_plan) begin
					count_q <= '0;
					peak_q <= '0;
				end
			end else if (state_q == gbop_pkg::ST_SCAN || state_q == gbop_pkg::ST_INSERT) begin
				step_q <= last_step ? '0 : step_q + 1'b1;
			end
			if (ring_load) begin
				inserted_q <= 1'b1;
				count_q <= count_q + 1'b1;
				if (end_sat > peak_q) peak_q <= end_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.id <= tensor_id;
			req_q.first <= first_use;
			req_q.last <= last_use;
			req_q.size <= tensor_size;
			req_q.offset <= '0;
		end
		if (state_q == gbop_pkg::ST_DONE) begin
			if (hit) begin
				off_q <= hit_off;
				stat_q <= gbop_pkg::StatusFound;
			end else if (!inserted_q) begin
				off_q <= '0;
				stat_q <= gbop_pkg::StatusFull;
			end else begin
				off_q <= new_off;
				stat_q <= gbop_pkg::StatusNew;
			end
		end
	end

	assign done = done_q;
	assign offset = off_q;
	assign status = stat_q;
	assign footprint = peak_q;

	// the entry count never exceeds the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH)) else $error("count beyond depth");
	// an insert pulse on ring_load never repeats back to back
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		ring_load |=> !ring_load) else $error("double insert");
	// results only after the done state
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == gbop_pkg::ST_DONE) else $error("stray result");
	// peak never shrinks without a new plan
	a_peak_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && new_plan) |=> peak_q >= $past(peak_q)) else $error("peak dropped");
endmodule
